@@ design/spmd_pkg.sv @@
// Package for the peak matching block: sizes, payload structs, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package spmd_pkg;
	localparam int MAX_PEAKS = 64;
	localparam int IDX_W = $clog2(MAX_PEAKS);
	localparam int CNT_W = $clog2(MAX_PEAKS + 1);

	localparam logic [1:0] ACT_OBS = 2'd0;
	localparam logic [1:0] ACT_THEO = 2'd1;
	localparam logic [1:0] ACT_RUN = 2'd2;

	localparam logic REG_TOL = 1'b0;
	localparam logic REG_SIDE = 1'b1;

	localparam logic [38:0] DEV_MAX = {39{1'b1}};

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] mass;
	} in_item_t;

	typedef struct packed {
		logic [5:0] entry_index;
		logic signed [39:0] relative_deviation;
		logic unmatched;
		logic [6:0] matched_count;
		logic load_overflow;
		logic last;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR,
		ST_WRD, ST_WRDW, ST_WCMP, ST_WNRD, ST_WNRDW, ST_WADV,
		ST_MRD, ST_MRDW, ST_MMUL, ST_MCMP,
		ST_ERD, ST_ERDW, ST_EDIV, ST_EOUT
	} state_t;
endpackage

@@ design/sorted_peak_match_deviation.sv @@
// Top level of the two-pointer peak matcher with relative deviations.
// Depends on spmd_pkg.
`timescale 1ns / 1ps
// Usage:
//  - Items are transferred on start/item while busy is low. action 0 appends
//    an observed mass, 1 a theoretical mass, 2 runs, 3 is ignored. A load
//    into a full list is dropped and flags load_overflow.
//  - Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data
//    (0 relative_tolerance, 1 report_side); cfg_ready is always high.
//  - A run walks both lists (skipped if either is empty), each walk step
//    going WRD, WRDW, WCMP, WNRD, WNRDW, WADV (up to No+Nt-1 steps), then
//    counts matches per theoretical entry (MRD, MRDW, MMUL, MCMP), then emits
//    one result per entry of the selected list. Each deviation is read (ERD,
//    ERDW), goes through a restoring divider, one quotient bit a cycle, then
//    a drain step, and is output in EOUT before the next entry is read.
//    The run start (ST_CLR) clears the per-entry seen bits.
//  - Each result is on result for one cycle with result_valid high; the
//    receiver cannot stall. The empty-list case gives one unmatched result.
//  - busy stays high from a run transfer until the cycle that carries its
//    last result; the next item can be transferred at the edge ending it.
//  - Reset clears counts, overflow flag and registers to their defaults;
//    the mass stores are undefined until loaded.
module sorted_peak_match_deviation (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input spmd_pkg::in_item_t item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [23:0] cfg_data,
	output logic result_valid,
	output spmd_pkg::out_item_t result
);
	localparam int IW = spmd_pkg::IDX_W;
	localparam int CW = spmd_pkg::CNT_W;

	logic [31:0] obs_mem [spmd_pkg::MAX_PEAKS];
	logic [31:0] theo_mem [spmd_pkg::MAX_PEAKS];
	logic signed [33:0] obest_mem [spmd_pkg::MAX_PEAKS];
	logic signed [33:0] tbest_mem [spmd_pkg::MAX_PEAKS];
	logic [spmd_pkg::MAX_PEAKS-1:0] oseen_q, tseen_q;

	logic [CW-1:0] ocnt_q, tcnt_q;
	logic ovf_q;
	logic [23:0] tol_q;
	logic side_q;

	spmd_pkg::state_t state_q, state_d;
	logic [IW:0] i_q, j_q;
	logic [31:0] ra_s1, rb_s1;
	logic [IW-1:0] oaddr, taddr;
	logic signed [33:0] obr_q, tbr_q;
	logic signed [33:0] d_q;
	logic [31:0] oi_q, tj_q;
	logic [CW-1:0] mcnt_q;
	logic [63:0] prod_q;
	logic [95:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0] bit_q;
	logic [33:0] dmag_q;
	logic neg_q;
	logic sub_q;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != spmd_pkg::ST_IDLE);

	function automatic logic [33:0] mag34(input logic signed [33:0] v);
		mag34 = v[33] ? 34'(-v) : 34'(v);
	endfunction

	// Memory read port addresses: one read per store per cycle.
	always_comb begin
		oaddr = i_q[IW-1:0];
		taddr = j_q[IW-1:0];
		if (state_q == spmd_pkg::ST_WNRD || state_q == spmd_pkg::ST_WNRDW) begin
			oaddr = IW'(i_q + 1'b1);
			taddr = IW'(j_q + 1'b1);
		end
		if (state_q == spmd_pkg::ST_ERD)
			taddr = i_q[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (start && !busy && item.action == spmd_pkg::ACT_OBS
				&& ocnt_q < CW'(spmd_pkg::MAX_PEAKS))
			obs_mem[ocnt_q[IW-1:0]] <= item.mass;
		if (start && !busy && item.action == spmd_pkg::ACT_THEO
				&& tcnt_q < CW'(spmd_pkg::MAX_PEAKS))
			theo_mem[tcnt_q[IW-1:0]] <= item.mass;
		ra_s1 <= obs_mem[oaddr];
		rb_s1 <= theo_mem[taddr];
		obr_q <= obest_mem[oaddr];
		tbr_q <= tbest_mem[taddr];
		if (state_q == spmd_pkg::ST_WCMP) begin
			if (!oseen_q[i_q[IW-1:0]] || mag34(d_q) <= mag34(obr_q))
				obest_mem[i_q[IW-1:0]] <= d_q;
			if (!tseen_q[j_q[IW-1:0]] || mag34(d_q) <= mag34(tbr_q))
				tbest_mem[j_q[IW-1:0]] <= d_q;
		end
	end

	logic adv_obs;
	logic [33:0] dn, dn2;
	logic [CW-1:0] nsel;

	always_comb begin
		dn = mag34(34'($signed({2'b0, ra_s1})) - 34'($signed({2'b0, tj_q})));
		dn2 = mag34(34'($signed({2'b0, ra_s1})) - 34'($signed({2'b0, rb_s1})));
		nsel = side_q ? tcnt_q : ocnt_q;
		adv_obs = 1'b0;
		if (d_q <= 0)
			adv_obs = 1'b1;
		else if (CW'(i_q) + 1'b1 >= ocnt_q)
			adv_obs = 1'b0;
		else
			adv_obs = ({30'd0, dn, 32'd0} <= {32'd0, prod_q})
				&& ((CW'(j_q) + 1'b1 >= tcnt_q) || (dn < dn2));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spmd_pkg::ST_IDLE:
				if (start && item.action == spmd_pkg::ACT_RUN) state_d = spmd_pkg::ST_CLR;
			spmd_pkg::ST_CLR:
				state_d = (ocnt_q != 0 && tcnt_q != 0) ? spmd_pkg::ST_WRD
					: spmd_pkg::ST_MRD;
			spmd_pkg::ST_WRD: state_d = spmd_pkg::ST_WRDW;
			spmd_pkg::ST_WRDW: state_d = spmd_pkg::ST_WCMP;
			spmd_pkg::ST_WCMP: state_d = spmd_pkg::ST_WNRD;
			spmd_pkg::ST_WNRD: state_d = spmd_pkg::ST_WNRDW;
			spmd_pkg::ST_WNRDW: state_d = spmd_pkg::ST_WADV;
			spmd_pkg::ST_WADV: begin
				if ((adv_obs && CW'(i_q) + 1'b1 >= ocnt_q)
						|| (!adv_obs && CW'(j_q) + 1'b1 >= tcnt_q))
					state_d = spmd_pkg::ST_MRD;
				else
					state_d = spmd_pkg::ST_WRD;
			end
			spmd_pkg::ST_MRD:
				state_d = (CW'(j_q) >= tcnt_q) ? spmd_pkg::ST_ERD : spmd_pkg::ST_MRDW;
			spmd_pkg::ST_MRDW: state_d = spmd_pkg::ST_MMUL;
			spmd_pkg::ST_MMUL: state_d = spmd_pkg::ST_MCMP;
			spmd_pkg::ST_MCMP: state_d = spmd_pkg::ST_MRD;
			spmd_pkg::ST_ERD: state_d = spmd_pkg::ST_ERDW;
			spmd_pkg::ST_ERDW: state_d = spmd_pkg::ST_EDIV;
			spmd_pkg::ST_EDIV: if (bit_q == 7'd0) state_d = spmd_pkg::ST_EOUT;
			spmd_pkg::ST_EOUT:
				if (nsel == 0 || CW'(i_q) + 1'b1 >= nsel) state_d = spmd_pkg::ST_IDLE;
				else state_d = spmd_pkg::ST_ERD;
			default: state_d = spmd_pkg::ST_IDLE;
		endcase
	end

	logic ok_e;
	logic [31:0] m_e;
	logic signed [33:0] b_e;
	logic [95:0] rem_sh;
	logic [38:0] qsat;

	always_comb begin
		m_e = side_q ? rb_s1 : ra_s1;
		b_e = side_q ? tbr_q : obr_q;
		ok_e = (side_q ? tseen_q[i_q[IW-1:0]] : oseen_q[i_q[IW-1:0]]) && m_e != 0;
		rem_sh = {rem_q[94:0], 1'b0};
		qsat = (quo_q > {25'd0, spmd_pkg::DEV_MAX}) ? spmd_pkg::DEV_MAX : quo_q[38:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spmd_pkg::ST_IDLE;
			ocnt_q <= '0;
			tcnt_q <= '0;
			ovf_q <= 1'b0;
			tol_q <= 24'd42950;
			side_q <= 1'b0;
			oseen_q <= '0;
			tseen_q <= '0;
			i_q <= '0;
			j_q <= '0;
			mcnt_q <= '0;
			bit_q <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == spmd_pkg::REG_TOL) tol_q <= cfg_data;
				else side_q <= cfg_data[0];
			end
			case (state_q)
				spmd_pkg::ST_IDLE:
					if (start) begin
						case (item.action)
							spmd_pkg::ACT_OBS:
								if (ocnt_q < CW'(spmd_pkg::MAX_PEAKS)) ocnt_q <= ocnt_q + 1'b1;
								else ovf_q <= 1'b1;
							spmd_pkg::ACT_THEO:
								if (tcnt_q < CW'(spmd_pkg::MAX_PEAKS)) tcnt_q <= tcnt_q + 1'b1;
								else ovf_q <= 1'b1;
							default: ;
						endcase
					end
				spmd_pkg::ST_CLR: begin
					oseen_q <= '0;
					tseen_q <= '0;
					i_q <= '0;
					j_q <= '0;
					mcnt_q <= '0;
				end
				spmd_pkg::ST_WRDW: begin
					oi_q <= ra_s1;
					tj_q <= rb_s1;
					d_q <= 34'($signed({2'b0, ra_s1})) - 34'($signed({2'b0, rb_s1}));
				end
				spmd_pkg::ST_WCMP: begin
					oseen_q[i_q[IW-1:0]] <= 1'b1;
					tseen_q[j_q[IW-1:0]] <= 1'b1;
					prod_q <= 64'(oi_q) * 64'(tol_q);
				end
				spmd_pkg::ST_WADV:
					if (adv_obs && CW'(i_q) + 1'b1 >= ocnt_q || !adv_obs && CW'(j_q) + 1'b1 >= tcnt_q)
						j_q <= '0;
					else if (adv_obs) i_q <= i_q + 1'b1;
					else j_q <= j_q + 1'b1;
				spmd_pkg::ST_MMUL: begin
					prod_q <= 64'(rb_s1) * 64'(tol_q);
					dmag_q <= mag34(tbr_q);
				end
				spmd_pkg::ST_MCMP: begin
					if (tseen_q[j_q[IW-1:0]] && rb_s1 != 0
							&& {30'd0, dmag_q, 32'd0} <= {32'd0, prod_q})
						mcnt_q <= mcnt_q + 1'b1;
					j_q <= j_q + 1'b1;
					i_q <= '0;
				end
				spmd_pkg::ST_MRD:
					if (CW'(j_q) >= tcnt_q) begin
						i_q <= '0;
						j_q <= '0;
					end
				spmd_pkg::ST_ERD: j_q <= i_q;
				spmd_pkg::ST_ERDW: begin
					dmag_q <= mag34(b_e);
					neg_q <= b_e[33];
					sub_q <= ok_e && nsel != 0;
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= 7'd65;
				end
				spmd_pkg::ST_EDIV: begin
					// Shift one dividend bit in per cycle, restoring subtract.
					if (bit_q != 7'd0) begin
						if (bit_q > 7'd1) begin
							if ((rem_sh[95:0] | 96'(({dmag_q, 32'd0} >> (bit_q - 7'd2)) & 66'd1))
									>= 96'(m_e)) begin
								rem_q <= (rem_sh | 96'(({dmag_q, 32'd0} >> (bit_q - 7'd2))
									& 66'd1)) - 96'(m_e);
								quo_q <= {quo_q[62:0], 1'b1};
							end else begin
								rem_q <= rem_sh | 96'(({dmag_q, 32'd0} >> (bit_q - 7'd2))
									& 66'd1);
								quo_q <= {quo_q[62:0], 1'b0};
							end
						end
						bit_q <= bit_q - 1'b1;
					end
				end
				spmd_pkg::ST_EOUT: begin
					result_valid <= 1'b1;
					result.entry_index <= i_q[IW-1:0];
					result.unmatched <= !sub_q;
					result.relative_deviation <= !sub_q ? 40'sd0
						: neg_q ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
					result.load_overflow <= ovf_q;
					if (nsel == 0 || CW'(i_q) + 1'b1 >= nsel) begin
						result.last <= 1'b1;
						result.matched_count <= 7'(mcnt_q);
						ocnt_q <= '0;
						tcnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						result.last <= 1'b0;
						result.matched_count <= '0;
					end
					i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
